@@ hw/rtl/soc_pkg.sv @@
// Shared types, constants and helpers for the substring occurrence counter.
`default_nettype none

package soc_pkg;

  localparam int unsigned MaxPatternDef = 16;
  localparam int unsigned CharW         = 8;
  localparam int unsigned CountW        = 16;
  localparam int unsigned CfgIndexW     = 2;
  localparam int unsigned CfgDataW      = 64;
  localparam int unsigned PatIdxW       = 4;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_PATTERN_LO = 2'd0,
    CFG_PATTERN_HI = 2'd1,
    CFG_LENGTH     = 2'd2
  } soc_cfg_e;

  typedef struct packed {
    logic [CharW-1:0] text_char;
    logic             last_char;
  } soc_in_t;

  typedef struct packed {
    logic              counted_here;
    logic [CountW-1:0] match_count;
    logic              end_of_text;
  } soc_out_t;

  // control shared by every cell of the window
  typedef struct packed {
    logic shift;
    logic clear;
  } soc_cell_ctl_t;

  function automatic logic [CharW-1:0] pattern_char(
    input logic [CfgDataW-1:0] lo,
    input logic [CfgDataW-1:0] hi,
    input logic [PatIdxW-1:0]  idx
  );
    logic [CfgDataW-1:0] word;
    word = idx[PatIdxW-1] ? hi : lo;
    return word[{idx[PatIdxW-2:0], 3'b000} +: CharW];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/soc_cell.sv @@
// One window cell: compares its incoming character and holds it for the next cell.
`default_nettype none

module soc_cell
  import soc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  soc_cell_ctl_t    ctl_i,
  input  logic [CharW-1:0] char_i,
  input  logic [CharW-1:0] expect_i,
  input  logic             active_i,
  output logic [CharW-1:0] char_o,
  output logic             match_o
);

  logic [CharW-1:0] char_q, char_d;

  assign match_o = !active_i || (char_i == expect_i);

  always_comb begin
    char_d = char_q;
    if (ctl_i.shift) begin
      char_d = ctl_i.clear ? '0 : char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q <= '0;
    end else begin
      char_q <= char_d;
    end
  end

  assign char_o = char_q;

endmodule

`default_nettype wire

@@ hw/rtl/soc_outbuf.sv @@
// Two-entry result buffer decoupling the input side from the output stall.
`default_nettype none

module soc_outbuf
  import soc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  soc_out_t data_i,
  output logic     full_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output soc_out_t out_data_o
);

  soc_out_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       pop;

  assign full_o      = fill_q[1];
  assign out_valid_o = (fill_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    unique case ({push_i, pop})
      2'b10:   fill_d = fill_q + 2'd1;
      2'b01:   fill_d = fill_q - 2'd1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/substring_occurrence_counter.sv @@
// Top level of the non-overlapping substring occurrence counter.
//
//  channel | direction | handshake       | payload
//  --------+-----------+-----------------+------------------------------------
//  in      | input     | valid / stall   | soc_in_t  (text_char, last_char)
//  out     | output    | valid / stall   | soc_out_t (counted_here, count, eot)
//  cfg     | input     | valid / ready   | register index, 64-bit data
//
//  One character per cycle unless stalled; its result enters a two-entry
//  buffer at the accepting edge and is offered behind any earlier results.
//  The window compare across the cell chain and the count update fit in the
//  accepting cycle, so a new character may follow every cycle unless stalled.
//  The input stalls only while both buffer entries hold untaken results.
//  Reset clears the window, counters and registers (length one).
`default_nettype none

module substring_occurrence_counter
  import soc_pkg::*;
#(
  parameter int unsigned MaxPattern = MaxPatternDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  soc_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output soc_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned LenW = $clog2(MaxPattern + 1);

  logic [CfgDataW-1:0] pat_lo_q, pat_lo_d;
  logic [CfgDataW-1:0] pat_hi_q, pat_hi_d;
  logic [LenW-1:0]     len_q, len_d;
  logic [LenW-1:0]     seen_q, seen_d;
  logic [LenW-1:0]     dist_q, dist_d;
  logic [CountW-1:0]   cnt_q, cnt_d;

  logic                accept;
  logic                full;
  logic                hit;
  logic                window_ok;
  logic [5:0]          len_raw;
  soc_cell_ctl_t       cell_ctl;
  soc_out_t            result;
  logic [CharW-1:0]    cell_char [MaxPattern];
  logic [MaxPattern-1:0] cell_match;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;

  // configuration; the length is clamped once, at write time
  assign len_raw = {1'b0, cfg_data_i[4:0]};

  always_comb begin
    pat_lo_d = pat_lo_q;
    pat_hi_d = pat_hi_q;
    len_d    = len_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PATTERN_LO: pat_lo_d = cfg_data_i;
        CFG_PATTERN_HI: pat_hi_d = cfg_data_i;
        CFG_LENGTH: begin
          if (len_raw == 6'd0) begin
            len_d = LenW'(1);
          end else if (len_raw > 6'(MaxPattern)) begin
            len_d = LenW'(MaxPattern);
          end else begin
            len_d = LenW'(len_raw);
          end
        end
        default: ;
      endcase
    end
  end

  // window of cells: cell j sees the character j places back
  assign cell_char[0]   = in_data_i.text_char;
  assign cell_ctl.shift = accept;
  assign cell_ctl.clear = in_data_i.last_char;

  for (genvar j = 0; j < MaxPattern; j++) begin : g_cell
    logic             active;
    logic [4:0]       idx_full;
    logic [CharW-1:0] expect_c;

    assign active   = (5'(j) < 5'(len_q));
    assign idx_full = 5'(len_q) - 5'(j + 1);
    assign expect_c = pattern_char(pat_lo_q, pat_hi_q, idx_full[PatIdxW-1:0]);

    if (j < MaxPattern - 1) begin : g_link
      soc_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctl_i    (cell_ctl),
        .char_i   (cell_char[j]),
        .expect_i (expect_c),
        .active_i (active),
        .char_o   (cell_char[j+1]),
        .match_o  (cell_match[j])
      );
    end else begin : g_tail
      soc_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctl_i    (cell_ctl),
        .char_i   (cell_char[j]),
        .expect_i (expect_c),
        .active_i (active),
        .char_o   (),
        .match_o  (cell_match[j])
      );
    end
  end

  // an occurrence needs enough text and must start after the last counted one
  assign window_ok = ((LenW+1)'(seen_q) + (LenW+1)'(1) >= (LenW+1)'(len_q)) &&
                     ((LenW+1)'(dist_q) + (LenW+1)'(1) >= (LenW+1)'(len_q));
  assign hit       = window_ok && (&cell_match);

  always_comb begin
    seen_d = seen_q;
    dist_d = dist_q;
    cnt_d  = cnt_q;
    if (accept) begin
      if (hit) begin
        dist_d = '0;
        if (cnt_q != '1) begin
          cnt_d = cnt_q + CountW'(1);
        end
      end else if (dist_q < LenW'(MaxPattern)) begin
        dist_d = dist_q + LenW'(1);
      end
      if (seen_q < LenW'(MaxPattern)) begin
        seen_d = seen_q + LenW'(1);
      end
    end
    result.counted_here = hit;
    result.match_count  = cnt_d;
    result.end_of_text  = in_data_i.last_char;
    if (accept && in_data_i.last_char) begin
      seen_d = '0;
      dist_d = LenW'(MaxPattern);
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      len_q    <= LenW'(1);
      seen_q   <= '0;
      dist_q   <= LenW'(MaxPattern);
      cnt_q    <= '0;
    end else begin
      pat_lo_q <= pat_lo_d;
      pat_hi_q <= pat_hi_d;
      len_q    <= len_d;
      seen_q   <= seen_d;
      dist_q   <= dist_d;
      cnt_q    <= cnt_d;
    end
  end

  soc_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (result),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/soc_checker.sv @@
// Port-level checks for the substring occurrence counter, bound to the top level.
`default_nettype none

module soc_checker
  import soc_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input soc_out_t out_data_o
);

  logic              out_acc;
  logic [CountW-1:0] prev_cnt_q;
  logic              prev_eot_q;
  logic [CountW-1:0] base_cnt;
  logic [CountW-1:0] next_cnt;

  assign out_acc  = out_valid_o && !out_stall_i;
  assign base_cnt = prev_eot_q ? '0 : prev_cnt_q;
  assign next_cnt = (base_cnt == '1) ? base_cnt : base_cnt + CountW'(1);

  // last delivered transaction, to follow the count from port values only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_cnt_q <= '0;
      prev_eot_q <= 1'b1;
    end else if (out_acc) begin
      prev_cnt_q <= out_data_o.match_count;
      prev_eot_q <= out_data_o.end_of_text;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or vanished");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with no result pending");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_data_o.counted_here |-> out_data_o.match_count == base_cnt)
    else $error("count moved without a counted occurrence");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_data_o.counted_here |-> out_data_o.match_count == next_cnt)
    else $error("count did not advance on a counted occurrence");

endmodule

bind substring_occurrence_counter soc_checker u_soc_checker (.*);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the non-overlapping substring occurrence counter.
module tb_top;
  import soc_pkg::*;

  localparam int unsigned MaxGap        = 18;
  localparam int unsigned HoldCycles    = 150;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned PhaseChars    = 56;
  localparam int unsigned PressureChars = 60;
  localparam int unsigned NumPhases     = 10;
  localparam logic [CfgIndexW-1:0] CfgIndexSpare = 2'd3;

  typedef enum int {
    IDLE_NONE,
    IDLE_LIGHT,
    IDLE_HEAVY
  } idle_mode_e;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  soc_in_t              in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  soc_out_t             out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i  = '0;

  // predictor copy of registers and text state
  logic [CfgDataW-1:0] pat_lo;
  logic [CfgDataW-1:0] pat_hi;
  logic [4:0]          pat_len_reg;
  logic [CharW-1:0]    text_window [MaxPatternDef-1];
  int                  win_seen;
  int                  gap_since_hit;
  int                  hit_total;

  soc_out_t   due_results [$];
  idle_mode_e src_mode      = IDLE_NONE;
  idle_mode_e sink_mode     = IDLE_NONE;
  bit         sink_hold_req = 1'b0;
  int         chars_sent    = 0;
  int         mismatches    = 0;
  int         quiet_cycles  = 0;

  substring_occurrence_counter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int draw_gap(idle_mode_e mode);
    case (mode)
      IDLE_NONE:  return 0;
      IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MaxGap) : 0;
      default:    return $urandom_range(0, MaxGap);
    endcase
  endfunction

  function automatic int active_len();
    if (pat_len_reg == 0) return 1;
    if (pat_len_reg > MaxPatternDef) return MaxPatternDef;
    return pat_len_reg;
  endfunction

  function automatic logic [CharW-1:0] pat_at(int k);
    logic [2*CfgDataW-1:0] pat_all;
    pat_all = {pat_hi, pat_lo};
    return pat_all[8*k +: 8];
  endfunction

  function automatic void clear_text();
    foreach (text_window[k]) text_window[k] = '0;
    win_seen      = 0;
    gap_since_hit = MaxPatternDef;
    hit_total     = 0;
  endfunction

  // one character in, one result out; the text state clears after the last one
  function automatic soc_out_t scan_char(soc_in_t item);
    soc_out_t res;
    int       len;
    bit       hit;
    len = active_len();
    hit = 1'b0;
    // a match may only start after the previous counted one ended
    if (win_seen + 1 >= len && gap_since_hit + 1 >= len) begin
      hit = (pat_at(len - 1) == item.text_char);
      for (int k = 0; k < len - 1; k++) begin
        if (text_window[len - 2 - k] != pat_at(k)) hit = 1'b0;
      end
    end
    if (hit) begin
      if (hit_total < 65535) hit_total++;
      gap_since_hit = 0;
    end else if (gap_since_hit < MaxPatternDef) begin
      gap_since_hit++;
    end
    if (win_seen < MaxPatternDef) win_seen++;
    for (int k = MaxPatternDef - 2; k > 0; k--) text_window[k] = text_window[k-1];
    text_window[0] = item.text_char;
    res.counted_here = hit;
    res.match_count  = hit_total[CountW-1:0];
    res.end_of_text  = item.last_char;
    if (item.last_char) clear_text();
    return res;
  endfunction

  // Caller sits just after an accepting edge, or idle.
  task automatic send_char(input logic [CharW-1:0] c, input bit last);
    int      gap;
    soc_in_t item;
    gap = draw_gap(src_mode);
    item.text_char = c;
    item.last_char = last;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    due_results.push_back(scan_char(item));
    chars_sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Random text: whole pattern copies, broken prefixes, pattern letters and noise.
  task automatic run_text(input int max_chars);
    logic [CharW-1:0] text_q [$];
    int               target;
    int               r;
    int               n;
    int               len;
    len    = active_len();
    target = $urandom_range(1, max_chars);
    while (text_q.size() < target) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        for (int k = 0; k < len; k++) text_q.push_back(pat_at(k));
      end else if (r < 6) begin
        n = $urandom_range(1, len);
        for (int k = 0; k < n; k++) text_q.push_back(pat_at(k));
      end else if (r < 9) begin
        text_q.push_back(pat_at($urandom_range(0, len - 1)));
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_PATTERN_LO: pat_lo = data;
      CFG_PATTERN_HI: pat_hi = data;
      CFG_LENGTH:     pat_len_reg = data[4:0];
      default:        ;
    endcase
  endtask

  task automatic configure(input logic [CfgDataW-1:0] lo, input logic [CfgDataW-1:0] hi,
                           input logic [CfgDataW-1:0] len_word);
    write_reg(CFG_PATTERN_LO, lo);
    write_reg(CFG_PATTERN_HI, hi);
    write_reg(CFG_LENGTH, len_word);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // input idle, every result in, then a settling wait for the pipeline to empty
  task automatic finish_phase();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic test_single_char_extremes();
    src_mode  = IDLE_HEAVY;
    sink_mode = IDLE_HEAVY;
    configure(64'hFFFF_FFFF_FFFF_FF00, 64'h0, 64'd1);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    finish_phase();
    // zero length behaves as one
    configure({CfgDataW{1'b1}}, {CfgDataW{1'b1}}, 64'd0);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    finish_phase();
  endtask

  task automatic test_non_overlap();
    src_mode  = IDLE_LIGHT;
    sink_mode = IDLE_NONE;
    configure(64'h0000_0000_0061_6261, 64'h0, 64'd3);
    send_string("ababa");
    send_string("ab");     // shorter than the pattern
    finish_phase();
    // spare index must leave the registers alone
    write_reg(CfgIndexSpare, {CfgDataW{1'b1}});
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    send_string("aba");
    finish_phase();
    configure(64'h0000_0000_0000_6161, 64'h0, 64'd2);
    send_string("aaaaa");
    finish_phase();
  endtask

  task automatic test_backpressure();
    int start;
    src_mode  = IDLE_NONE;
    sink_mode = IDLE_LIGHT;
    configure({CfgDataW{1'b1}}, {CfgDataW{1'b1}}, 64'd16);
    sink_hold_req = 1'b1;
    start = chars_sent;
    while (chars_sent - start < PressureChars) run_text(3 * active_len() + 6);
    finish_phase();
  endtask

  task automatic test_random_texts();
    logic [4:0]            phase_lens [NumPhases] = '{5'd1, 5'd16, 5'd2, 5'd0, 5'd31,
                                                     5'd5, 5'd17, 5'd9, 5'd3, 5'd12};
    logic [CharW-1:0]      alphabet [3];
    logic [2*CfgDataW-1:0] pat;
    logic [CfgDataW-1:0]   len_word;
    int                    start;
    for (int p = 0; p < NumPhases; p++) begin
      foreach (alphabet[k]) alphabet[k] = 8'($urandom_range(0, 255));
      // small alphabet so that overlapping candidates are common
      for (int k = 0; k < MaxPatternDef; k++) begin
        pat[8*k +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                    : alphabet[$urandom_range(0, 2)];
      end
      len_word      = (p % 2 == 1) ? {$urandom(), $urandom()} : '0;
      len_word[4:0] = phase_lens[p];
      src_mode      = idle_mode_e'(p % 3);
      sink_mode     = idle_mode_e'((p / 2) % 3);
      configure(pat[CfgDataW-1:0], pat[2*CfgDataW-1:CfgDataW], len_word);
      start = chars_sent;
      while (chars_sent - start < PhaseChars) run_text(3 * active_len() + 6);
      finish_phase();
    end
  endtask

  // result side: per-transaction stall gaps, plus one long hold-off on request
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
      end else begin
        gap = draw_gap(sink_mode);
        if (gap > 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(negedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    soc_out_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        if (mismatches < MaxReports)
          $display("unexpected result: hit=%0b count=%0d end=%0b",
                   out_data_o.counted_here, out_data_o.match_count, out_data_o.end_of_text);
        mismatches++;
      end else begin
        exp_res = due_results.pop_front();
        if (out_data_o.counted_here !== exp_res.counted_here ||
            out_data_o.match_count  !== exp_res.match_count  ||
            out_data_o.end_of_text  !== exp_res.end_of_text) begin
          if (mismatches < MaxReports)
            $display("mismatch: expected hit=%0b count=%0d end=%0b, got hit=%0b count=%0d end=%0b",
                     exp_res.counted_here, exp_res.match_count, exp_res.end_of_text,
                     out_data_o.counted_here, out_data_o.match_count, out_data_o.end_of_text);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    pat_lo      = '0;
    pat_hi      = '0;
    pat_len_reg = 5'd1;
    clear_text();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_single_char_extremes();
    test_non_overlap();
    test_backpressure();
    test_random_texts();
    finish_phase();
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
